FILE: design/websocket_frame_deframer_assert.svh
// ============================================================================
// WebSocket frame deframer assertion macros
// Shared concurrent assertion forms, compiled out for synthesis.
// ============================================================================
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset.
`define WSFD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define WSFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define WSFD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define WSFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: design/wsfd_pkg.sv
// ============================================================================
// WebSocket frame deframer package
// Result record and result kind codes shared by the deframer modules.
// ============================================================================
package wsfd_pkg;

    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_DATA   = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic        fin_flag;
        logic        rsv1_flag;
        logic        rsv2_flag;
        logic        rsv3_flag;
        logic [3:0]  opcode;
        logic        masked;
        logic [63:0] frame_length;
        logic        last;
    } res_t;

endpackage

FILE: design/wsfd_parser.sv
// ============================================================================
// WebSocket frame deframer: header parser and unmasker
// Walks the frame header one byte per transaction, then unmasks payload bytes.
// ============================================================================
`include "websocket_frame_deframer_assert.svh"

module wsfd_parser
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        stream_byte,
    output logic              res_push,
    output wsfd_pkg::res_t    res
);

    import wsfd_pkg::*;

    typedef enum logic [2:0] {
        PH_FIRST  = 3'd0,
        PH_SECOND = 3'd1,
        PH_EXT16  = 3'd2,
        PH_EXT64  = 3'd3,
        PH_KEY    = 3'd4,
        PH_DATA   = 3'd5
    } phase_t;

    localparam logic [6:0] LEN16_CODE = 7'h7E;
    localparam logic [6:0] LEN64_CODE = 7'h7F;
    localparam logic [2:0] EXT16_LAST = 3'd1;
    localparam logic [2:0] EXT64_LAST = 3'd7;
    localparam logic [2:0] KEY_LAST   = 3'd3;

    phase_t      phase_reg, phase_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [63:0] len_reg, len_next;
    logic [63:0] left_reg, left_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  lane_reg, lane_next;
    logic        mask_reg, mask_next;
    logic [7:0]  hdr_reg, hdr_next;

    logic        after_len;
    logic        finish;
    logic        res_kind;
    logic [7:0]  res_data;
    logic        res_last;
    logic [31:0] key_shifted;

    // Key lane 0 sits in the top byte, so the shift is (3 - lane) bytes.
    assign key_shifted = key_reg >> {~lane_reg, 3'b000};

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        len_next   = len_reg;
        left_next  = left_reg;
        key_next   = key_reg;
        lane_next  = lane_reg;
        mask_next  = mask_reg;
        hdr_next   = hdr_reg;
        after_len  = 1'b0;
        finish     = 1'b0;
        res_push   = 1'b0;
        res_kind   = KIND_HEADER;
        res_data   = 8'h00;
        res_last   = 1'b0;

        if (accept)
        begin
            unique case (phase_reg)
                PH_SECOND:
                begin
                    mask_next = stream_byte[7];
                    cnt_next  = 3'd0;
                    if (stream_byte[6:0] == LEN16_CODE)
                    begin
                        len_next   = 64'd0;
                        phase_next = PH_EXT16;
                    end
                    else if (stream_byte[6:0] == LEN64_CODE)
                    begin
                        len_next   = 64'd0;
                        phase_next = PH_EXT64;
                    end
                    else
                    begin
                        len_next  = {57'd0, stream_byte[6:0]};
                        after_len = 1'b1;
                    end
                end
                PH_EXT16, PH_EXT64:
                begin
                    len_next = {len_reg[55:0], stream_byte};
                    if (cnt_reg >= ((phase_reg == PH_EXT16) ? EXT16_LAST : EXT64_LAST))
                    begin
                        after_len = 1'b1;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
                PH_KEY:
                begin
                    key_next = {key_reg[23:0], stream_byte};
                    if (cnt_reg >= KEY_LAST)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 3'd1;
                    end
                end
                PH_DATA:
                begin
                    res_push  = 1'b1;
                    res_kind  = KIND_DATA;
                    res_data  = stream_byte ^ (mask_reg ? key_shifted[7:0] : 8'h00);
                    res_last  = (left_reg <= 64'd1);
                    lane_next = lane_reg + 2'd1;
                    if (left_reg != 64'd0)
                    begin
                        left_next = left_reg - 64'd1;
                    end
                    if (res_last)
                    begin
                        phase_next = PH_FIRST;
                    end
                end
                default:
                begin
                    hdr_next   = stream_byte;
                    phase_next = PH_SECOND;
                    cnt_next   = 3'd0;
                end
            endcase

            // Length complete: a masked frame still needs its four key bytes.
            if (after_len)
            begin
                cnt_next = 3'd0;
                key_next = 32'd0;
                if (mask_next)
                begin
                    phase_next = PH_KEY;
                end
                else
                begin
                    finish = 1'b1;
                end
            end

            if (finish)
            begin
                res_push   = 1'b1;
                res_kind   = KIND_HEADER;
                res_last   = (len_next == 64'd0);
                left_next  = len_next;
                lane_next  = 2'd0;
                cnt_next   = 3'd0;
                phase_next = res_last ? PH_FIRST : PH_DATA;
            end
        end
    end

    always_comb
    begin
        res.kind           = res_kind;
        res.payload_byte   = res_data;
        res.fin_flag       = hdr_next[7];
        res.rsv1_flag      = hdr_next[6];
        res.rsv2_flag      = hdr_next[5];
        res.rsv3_flag      = hdr_next[4];
        res.opcode         = hdr_next[3:0];
        res.masked         = mask_next;
        res.frame_length   = len_next;
        res.last           = res_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
            cnt_reg   <= 3'd0;
            len_reg   <= 64'd0;
            left_reg  <= 64'd0;
            key_reg   <= 32'd0;
            lane_reg  <= 2'd0;
            mask_reg  <= 1'b0;
            hdr_reg   <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
            key_reg   <= key_next;
            lane_reg  <= lane_next;
            mask_reg  <= mask_next;
            hdr_reg   <= hdr_next;
        end
    end

    `WSFD_ASSERT_IMPL(a_data_gives_result, clk, rst_n, accept && phase_reg == PH_DATA, res_push && res.kind == KIND_DATA, "payload byte did not produce a payload result")
    `WSFD_ASSERT_NEXT(a_last_returns_first, clk, rst_n, res_push && res.last, phase_reg == PH_FIRST, "frame end did not return to the first header byte")
    `WSFD_ASSERT_IMPL(a_key_only_masked, clk, rst_n, phase_reg == PH_KEY, mask_reg, "key bytes expected on an unmasked frame")

endmodule

FILE: design/wsfd_out_buf.sv
// ============================================================================
// WebSocket frame deframer: result buffer
// Two-entry result queue that decouples the parser from a stalling consumer.
// ============================================================================
`include "websocket_frame_deframer_assert.svh"

module wsfd_out_buf
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  wsfd_pkg::res_t    push_res,
    output logic              full,
    output logic              res_valid,
    input  logic              res_stall,
    output wsfd_pkg::res_t    head
);

    import wsfd_pkg::*;

    res_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign res_valid = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign pop       = res_valid && !res_stall;
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_res;
        end
    end

    `WSFD_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg != 2'd3, "result queue count out of range")
    `WSFD_ASSERT_IMPL(a_no_push_full, clk, rst_n, push, !full, "result written into a full queue")
    `WSFD_ASSERT_NEXT(a_count_grows, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 2'd1, "queue count did not grow on a lone write")

endmodule

FILE: design/websocket_frame_deframer.sv
// ============================================================================
// WebSocket frame deframer
// Parses a WebSocket frame stream byte by byte into header and payload results.
// ============================================================================
//
//   channel   valid       stall       payload
//   input     byte_valid  byte_stall  stream_byte
//   result    res_valid   res_stall   kind, payload_byte, header fields, last
//
// Each accepted byte is handled in the cycle it is taken; its result, if any,
// is held in the result queue from the next cycle. One byte can be taken
// every cycle while results drain without stalls.
// After reset the block expects the first header byte of a new frame.
// Results wait in a two-entry queue; byte_stall is high while both entries
// are occupied, even for bytes that would yield no result.
// ============================================================================
module websocket_frame_deframer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  stream_byte,
    output logic        res_valid,
    input  logic        res_stall,
    output logic        kind,
    output logic [7:0]  payload_byte,
    output logic        fin_flag,
    output logic        rsv1_flag,
    output logic        rsv2_flag,
    output logic        rsv3_flag,
    output logic [3:0]  opcode,
    output logic        masked,
    output logic [63:0] frame_length,
    output logic        last
);

    import wsfd_pkg::*;

    logic accept;
    logic full;
    logic push;
    res_t push_res;
    res_t head;

    assign byte_stall = full;
    assign accept     = byte_valid && !full;

    wsfd_parser u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .stream_byte (stream_byte),
        .res_push    (push),
        .res         (push_res)
    );

    wsfd_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_res  (push_res),
        .full      (full),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .head      (head)
    );

    assign kind           = head.kind;
    assign payload_byte   = head.payload_byte;
    assign fin_flag       = head.fin_flag;
    assign rsv1_flag      = head.rsv1_flag;
    assign rsv2_flag      = head.rsv2_flag;
    assign rsv3_flag      = head.rsv3_flag;
    assign opcode         = head.opcode;
    assign masked         = head.masked;
    assign frame_length   = head.frame_length;
    assign last           = head.last;

endmodule
